// ===== design/bse_pkg.sv =====
// Shared types, constants and the character table for the base64 line-wrapped encoder.
`default_nettype none

package bse_pkg;

   localparam int unsigned WRAP_W         = 10;
   localparam int unsigned LINE_COUNT_W   = 11;
   localparam int unsigned MAX_CHARS      = 5;
   localparam int unsigned COUNT_W        = 3;

   localparam logic [WRAP_W-1:0]       WRAP_RESET     = 10'd76;
   localparam logic [LINE_COUNT_W-1:0] LINE_COUNT_MAX = 11'd2047;
   localparam logic [7:0]              CHAR_PAD       = 8'h3D;
   localparam logic [7:0]              CHAR_NEWLINE   = 8'h0A;

   localparam logic [1:0] PHASE_FIRST  = 2'd0;
   localparam logic [1:0] PHASE_SECOND = 2'd1;
   localparam logic [1:0] PHASE_THIRD  = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic       run_last;
      logic       text_last;
   } rsp_type;

   typedef struct packed {
      logic [MAX_CHARS-1:0][7:0] chars;
      logic [COUNT_W-1:0]        count;
      logic                      last;
   } burst_type;

   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      logic [7:0] code;
      code = {2'b00, v};
      if (v < 6'd26) begin
         sextet_char = 8'h41 + code;
      end else if (v < 6'd52) begin
         sextet_char = 8'h61 + code - 8'd26;
      end else if (v < 6'd62) begin
         sextet_char = 8'h30 + code - 8'd52;
      end else if (v == 6'd62) begin
         sextet_char = 8'h2B;
      end else begin
         sextet_char = 8'h2F;
      end
   endfunction

endpackage

`default_nettype wire

// ===== design/base64_line_wrapped_encoder.sv =====
// Top level of the streaming base64 encoder with fixed-length line wrapping.
//
// Request channel (req_valid, req_stall, req_data) carries one message byte
// and a flag on the message's final byte. Result channel (rsp_valid,
// rsp_stall, rsp_data) carries one ASCII character per transfer, with
// run_last on the last character of a byte's burst and text_last on the
// final character of the message. The csr channel writes the line length
// (0 turns wrapping off); csr_ready is always high; write only when idle.
// A request passes the input register and then the result register before
// its first character appears. Each request yields 1 to 5 characters and
// holds the result port until its last character is taken; the input
// register takes the next request while the current burst drains. The
// character port, one character per cycle while rsp_stall is low, bounds
// the sustained byte rate.
// Reset clears the encoder phase and line count, empties both registers and
// restores a line length of 76. While rsp_stall is high the character and
// flags hold; req_stall is high while the input register is full and not loading.
`default_nettype none

module base64_line_wrapped_encoder (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output      logic                        req_stall,
   input  wire bse_pkg::req_type            req_data,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_stall,
   output      bse_pkg::rsp_type            rsp_data,
   input  wire logic                        csr_valid,
   output      logic                        csr_ready,
   input  wire logic [bse_pkg::WRAP_W-1:0]  csr_wdata
);
   import bse_pkg::*;

   logic [WRAP_W-1:0] line_wrap_ff;
   logic              take;
   logic              load;
   burst_type         burst;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_wrap_ff <= WRAP_RESET;
      end else if (csr_valid && csr_ready) begin
         line_wrap_ff <= csr_wdata;
      end
   end

   bse_encode u_encode (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .line_wrap (line_wrap_ff),
      .take      (take),
      .load      (load),
      .burst     (burst)
   );

   bse_serial u_serial (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .burst     (burst),
      .take      (take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== design/bse_encode.sv =====
// Input register, encoder state and the per-byte character burst logic.
`default_nettype none

module bse_encode (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output      logic                        req_stall,
   input  wire bse_pkg::req_type            req_data,
   input  wire logic [bse_pkg::WRAP_W-1:0]  line_wrap,
   input  wire logic                        take,
   output      logic                        load,
   output      bse_pkg::burst_type          burst
);
   import bse_pkg::*;

   logic                    in_valid_ff;
   logic                    in_valid_in;
   req_type                 in_data_ff;
   logic [1:0]              phase_ff;
   logic [1:0]              phase_in;
   logic [3:0]              held_ff;
   logic [3:0]              held_in;
   logic [LINE_COUNT_W-1:0] line_count_ff;
   logic [LINE_COUNT_W-1:0] line_count_in;
   logic                    req_accept;
   logic                    wrap_hit;
   logic [COUNT_W-1:0]      counted;
   logic [LINE_COUNT_W-1:0] line_base;
   logic [LINE_COUNT_W:0]   line_sum;
   logic [7:0]              b;
   logic [7:0]              g0;
   logic [7:0]              g1;

   assign load       = in_valid_ff && take;
   assign req_stall  = in_valid_ff && !load;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (load) begin
         in_valid_in = 1'b0;
      end
   end

   assign b        = in_data_ff.data_byte;
   assign wrap_hit = (line_wrap != '0) && (line_count_ff >= {1'b0, line_wrap});
   assign g0       = sextet_char(b[7:2]);
   assign g1       = sextet_char({b[1:0], 4'b0000});

   always_comb begin
      burst.chars = '0;
      burst.count = '0;
      burst.last  = in_data_ff.last_byte;
      counted     = '0;
      line_base   = line_count_ff;
      phase_in    = phase_ff;
      held_in     = held_ff;
      case (phase_ff)
         PHASE_SECOND: begin
            burst.chars[0] = sextet_char({held_ff[1:0], b[7:4]});
            held_in        = b[3:0];
            phase_in       = PHASE_THIRD;
            if (in_data_ff.last_byte) begin
               burst.chars[1] = sextet_char({b[3:0], 2'b00});
               burst.chars[2] = CHAR_PAD;
               burst.count    = 3'd3;
            end else begin
               burst.count = 3'd1;
            end
            counted = burst.count;
         end
         PHASE_THIRD: begin
            burst.chars[0] = sextet_char({held_ff, b[7:6]});
            burst.chars[1] = sextet_char(b[5:0]);
            burst.count    = 3'd2;
            counted        = 3'd2;
            held_in        = '0;
            phase_in       = PHASE_FIRST;
         end
         default: begin
            counted = in_data_ff.last_byte ? 3'd4 : 3'd1;
            if (wrap_hit) begin
               burst.chars = {CHAR_PAD, CHAR_PAD, g1, g0, CHAR_NEWLINE};
               line_base   = '0;
            end else begin
               burst.chars = {8'h00, CHAR_PAD, CHAR_PAD, g1, g0};
            end
            burst.count = counted + {2'b00, wrap_hit};
            held_in     = {2'b00, b[1:0]};
            phase_in    = PHASE_SECOND;
         end
      endcase
      line_sum = {1'b0, line_base} + {{(LINE_COUNT_W-COUNT_W+1){1'b0}}, counted};
      if (line_sum > {1'b0, LINE_COUNT_MAX}) begin
         line_count_in = LINE_COUNT_MAX;
      end else begin
         line_count_in = line_sum[LINE_COUNT_W-1:0];
      end
      if (in_data_ff.last_byte) begin
         phase_in      = PHASE_FIRST;
         held_in       = '0;
         line_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         phase_ff      <= PHASE_FIRST;
         held_ff       <= '0;
         line_count_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (load) begin
            phase_ff      <= phase_in;
            held_ff       <= held_in;
            line_count_ff <= line_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
   end

endmodule

`default_nettype wire

// ===== design/bse_serial.sv =====
// Result register that holds one burst and gives a character per cycle unless stalled.
`default_nettype none

module bse_serial (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               load,
   input  wire bse_pkg::burst_type burst,
   output      logic               take,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      bse_pkg::rsp_type   rsp_data
);
   import bse_pkg::*;

   logic               valid_ff;
   burst_type          burst_ff;
   logic [COUNT_W-1:0] idx_ff;
   logic               final_char;
   logic               rsp_accept;

   assign final_char = idx_ff == (burst_ff.count - 3'd1);
   assign rsp_accept = valid_ff && !rsp_stall;
   assign take       = !valid_ff || (rsp_accept && final_char);

   assign rsp_valid          = valid_ff;
   assign rsp_data.char_out  = burst_ff.chars[idx_ff];
   assign rsp_data.run_last  = final_char;
   assign rsp_data.text_last = final_char && burst_ff.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= '0;
      end else if (rsp_accept) begin
         if (final_char) begin
            valid_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         burst_ff <= burst;
      end
   end

endmodule

`default_nettype wire

// ===== design/bse_checker.sv =====
// Port-level assertions for the base64 encoder and the bind that attaches them.
`default_nettype none

module bse_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire bse_pkg::rsp_type rsp_data
);
   import bse_pkg::*;

   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_hold_stalled : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_text_in_run : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.text_last |-> rsp_data.run_last)
      else $error("message end outside burst end");

   a_burst_continues : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.run_last |=> rsp_valid)
      else $error("burst broken before its last character");

   a_newline_leads : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.char_out == CHAR_NEWLINE |-> !rsp_data.run_last)
      else $error("newline ended a burst");

endmodule

bind base64_line_wrapped_encoder bse_checker u_bse_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
